[hdl/nsp_pkg.sv]
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared types, constants and helpers for the NMEA sentence parser.
// ----------------------------------------------------------------------------
package nsp_pkg;

    localparam int FRACTION_DIGITS_DEF = 4;
    localparam int MAX_FIELDS_DEF      = 32;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;

    localparam logic [47:0] HDR_GGA = 48'h41_47_47_50_47_24;
    localparam logic [47:0] HDR_RMC = 48'h43_4D_52_50_47_24;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_GGA   = 2'd1;
    localparam logic [1:0] KIND_RMC   = 2'd2;

    localparam logic [1:0] STG_INT  = 2'd0;
    localparam logic [1:0] STG_FRAC = 2'd1;
    localparam logic [1:0] STG_DONE = 2'd2;

    typedef struct packed {
        logic [16:0] ipart;
        logic [16:0] frac;
        logic [2:0]  fcount;
        logic [1:0]  stage;
    } coord_t;

    // Snapshot of one finished sentence handed to the result stage.
    typedef struct packed {
        logic [1:0]  kind;
        logic        ok;
        logic [7:0]  fix;
        logic [7:0]  status;
        logic [23:0] tdig;
        logic [23:0] ddig;
        coord_t      lat;
        coord_t      lon;
        logic [1:0]  hemi;
    } sent_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (CH_ZERO + {4'd0, nib}) : (CH_A + {4'd0, nib} - 8'd10);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // low nibble holds the tens digit (first character of the pair)
    function automatic logic [6:0] two_digits(input logic [7:0] d);
        return 7'({3'd0, d[3:0]} * 7'd10 + {3'd0, d[7:4]});
    endfunction

endpackage

[hdl/nsp_scan.sv]
// ----------------------------------------------------------------------------
// nsp_scan
// Per-byte sentence scanner: checksum, field split and field capture.
// ----------------------------------------------------------------------------
module nsp_scan
    import nsp_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF,
    parameter int MAX_FIELDS      = MAX_FIELDS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    input  logic [7:0] c,
    output logic       done,
    output sent_t      sent
);
    localparam int FW = $clog2(MAX_FIELDS);

    logic        in_s_reg, sum_reg, cap_reg;
    logic [7:0]  xor_reg;
    logic [15:0] rck_reg;
    logic [1:0]  cnt_reg;
    logic [FW-1:0] fld_reg;
    logic [3:0]  pos_reg, hlen_reg;
    logic [47:0] hdr_reg;
    logic [7:0]  fix_reg, sta_reg;
    logic [23:0] tdig_reg, ddig_reg;
    coord_t      lat_reg, lon_reg;
    logic [1:0]  hemi_reg;

    logic        in_s_next, sum_next, cap_next;
    logic [7:0]  xor_next;
    logic [15:0] rck_next;
    logic [1:0]  cnt_next;
    logic [FW-1:0] fld_next;
    logic [3:0]  pos_next, hlen_next, hl_fin;
    logic [47:0] hdr_next;
    logic [7:0]  fix_next, sta_next;
    logic [23:0] tdig_next, ddig_next;
    coord_t      lat_next, lon_next;
    logic [1:0]  hemi_next;

    function automatic coord_t feed(input coord_t a, input logic [7:0] ch);
        coord_t r;
        logic [20:0] t;
        r = a;
        t = 21'(a.ipart) * 21'd10 + {17'd0, ch[3:0]};
        if (a.stage == STG_INT) begin
            if (is_digit(ch))
                r.ipart = (t > 21'd99999) ? 17'd99999 : t[16:0];
            else if (ch == CH_DOT)
                r.stage = STG_FRAC;
            else
                r.stage = STG_DONE;
        end else if (a.stage == STG_FRAC) begin
            if (is_digit(ch)) begin
                if (32'(a.fcount) < FRACTION_DIGITS) begin
                    r.frac   = 17'(21'(a.frac) * 21'd10 + {17'd0, ch[3:0]});
                    r.fcount = a.fcount + 3'd1;
                end
            end else begin
                r.stage = STG_DONE;
            end
        end
        return r;
    endfunction

    always_comb
    begin
        logic fin, go;
        logic [3:0] dg;
        in_s_next = in_s_reg; sum_next = sum_reg; cap_next = cap_reg;
        xor_next = xor_reg; rck_next = rck_reg; cnt_next = cnt_reg;
        fld_next = fld_reg; pos_next = pos_reg; hlen_next = hlen_reg;
        hdr_next = hdr_reg; fix_next = fix_reg; sta_next = sta_reg;
        tdig_next = tdig_reg; ddig_next = ddig_reg;
        lat_next = lat_reg; lon_next = lon_reg; hemi_next = hemi_reg;
        fin = 1'b0;
        dg = is_digit(c) ? c[3:0] : 4'd0;
        if (valid && c == CH_DOLLAR) begin
            in_s_next = 1'b1; sum_next = 1'b0; cap_next = 1'b0;
            xor_next = '0; rck_next = '0; cnt_next = '0; fld_next = '0;
            pos_next = '0; hlen_next = '0; hdr_next = '0; fix_next = '0;
            sta_next = '0; tdig_next = '0; ddig_next = '0;
            lat_next = '0; lon_next = '0; hemi_next = '0;
        end
        go = valid && (in_s_reg || c == CH_DOLLAR);
        if (go && (c == CH_CR || c == CH_LF)) begin
            fin = 1'b1;
            in_s_next = 1'b0;
        end else if (go) begin
            if (sum_next && c == CH_STAR) sum_next = 1'b0;
            if (sum_next) xor_next = xor_next ^ c;
            if (c == CH_DOLLAR) sum_next = 1'b1;
            if (cap_next) begin
                if (cnt_next == 2'd0) rck_next[7:0] = c;
                if (cnt_next == 2'd1) rck_next[15:8] = c;
                if (cnt_next != 2'd3) cnt_next = cnt_next + 2'd1;
            end
            if (c == CH_STAR) cap_next = 1'b1;
            if (c == CH_COMMA) begin
                if (fld_next == '0) hlen_next = pos_next;
                if (32'(fld_next) < MAX_FIELDS - 1) fld_next = fld_next + FW'(1);
                pos_next = '0;
            end else begin
                if (fld_next == FW'(0) && pos_next < 4'd6)
                    hdr_next[pos_next[2:0]*8 +: 8] = c;
                if (fld_next == FW'(1) && pos_next < 4'd6)
                    tdig_next[pos_next[2:0]*4 +: 4] = dg;
                if (fld_next == FW'(9) && pos_next < 4'd6)
                    ddig_next[pos_next[2:0]*4 +: 4] = dg;
                if (fld_next == FW'(2)) lat_next = feed(lat_next, c);
                if (fld_next == FW'(4)) lon_next = feed(lon_next, c);
                if (pos_next == 4'd0) begin
                    if (fld_next == FW'(6)) fix_next = c;
                    if (fld_next == FW'(2)) sta_next = c;
                    if (fld_next == FW'(3) && c == CH_S) hemi_next[0] = 1'b1;
                    if (fld_next == FW'(5) && c == CH_W) hemi_next[1] = 1'b1;
                end
                if (pos_next != 4'd15) pos_next = pos_next + 4'd1;
            end
        end
        // finish: snapshot from current registers
        hl_fin = (fld_reg == '0) ? pos_reg : hlen_reg;
        done = fin;
        sent.kind = KIND_OTHER;
        if (hl_fin == 4'd6 && hdr_reg == HDR_GGA) sent.kind = KIND_GGA;
        else if (hl_fin == 4'd6 && hdr_reg == HDR_RMC) sent.kind = KIND_RMC;
        sent.ok = (cnt_reg >= 2'd2) && (rck_reg[7:0] == hex_char(xor_reg[7:4]))
                  && (rck_reg[15:8] == hex_char(xor_reg[3:0]));
        sent.fix = fix_reg; sent.status = sta_reg;
        sent.tdig = tdig_reg; sent.ddig = ddig_reg;
        sent.lat = lat_reg; sent.lon = lon_reg; sent.hemi = hemi_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_s_reg <= 1'b0; sum_reg <= 1'b0; cap_reg <= 1'b0;
            xor_reg <= '0; rck_reg <= '0; cnt_reg <= '0; fld_reg <= '0;
            pos_reg <= '0; hlen_reg <= '0; hdr_reg <= '0; fix_reg <= '0;
            sta_reg <= '0; tdig_reg <= '0; ddig_reg <= '0;
            lat_reg <= '0; lon_reg <= '0; hemi_reg <= '0;
        end
        else
        begin
            in_s_reg <= in_s_next; sum_reg <= sum_next; cap_reg <= cap_next;
            xor_reg <= xor_next; rck_reg <= rck_next; cnt_reg <= cnt_next;
            fld_reg <= fld_next; pos_reg <= pos_next; hlen_reg <= hlen_next;
            hdr_reg <= hdr_next; fix_reg <= fix_next; sta_reg <= sta_next;
            tdig_reg <= tdig_next; ddig_reg <= ddig_next;
            lat_reg <= lat_next; lon_reg <= lon_next; hemi_reg <= hemi_next;
        end
    end
endmodule

[hdl/nsp_result.sv]
// ----------------------------------------------------------------------------
// nsp_result
// Checks a finished sentence, updates held fields and drives the result
// register with a skid stage.
// ----------------------------------------------------------------------------
module nsp_result
    import nsp_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         done,
    input  sent_t        sent,
    output logic         can_take,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata
);
    localparam longint SCALE    = 10 ** FRACTION_DIGITS;
    localparam int     LW       = 34;
    // ceil(2^24 / 100): exact divide by 100 for integer parts up to 99999
    localparam int     DIV100_K = 167773;

    logic        pv_reg, dv_reg;
    logic [6:0]  hh_reg, mi_reg, ss_reg, dd_reg, mo_reg, yy_reg;
    logic [26:0] lat_reg;
    logic [27:0] lon_reg;
    logic [103:0] out_reg, skid_reg;
    logic        ov_reg, sv_reg;

    function automatic logic [LW-1:0] mag(input coord_t a, input longint maxd);
        logic [LW-1:0] f, m, lim;
        logic [33:0]   prod;
        logic [9:0]    deg;
        logic [16:0]   mins;
        f = LW'(a.frac);
        for (int n = 0; n < 5; n++)
            if (n >= 32'(a.fcount) && n < FRACTION_DIGITS) f = LW'(f * LW'(10));
        // split ddmm into degrees and minutes by reciprocal multiply
        prod = 34'(a.ipart) * 34'(DIV100_K);
        deg  = prod[33:24];
        mins = a.ipart - 17'(deg) * 17'd100;
        m = LW'(deg) * LW'(60 * SCALE) + LW'(mins) * LW'(SCALE) + f;
        lim = LW'(maxd * 60 * SCALE);
        return (m > lim) ? lim : m;
    endfunction

    logic        pv_next, dv_next;
    logic [6:0]  hh_next, mi_next, ss_next, dd_next, mo_next, yy_next;
    logic [26:0] lat_next;
    logic [27:0] lon_next;
    logic [103:0] res;
    logic [LW-1:0] mla, mlo;

    always_comb
    begin
        pv_next = pv_reg; dv_next = dv_reg;
        hh_next = hh_reg; mi_next = mi_reg; ss_next = ss_reg;
        dd_next = dd_reg; mo_next = mo_reg; yy_next = yy_reg;
        lat_next = lat_reg; lon_next = lon_reg;
        mla = mag(sent.lat, 90);
        mlo = mag(sent.lon, 180);
        if (sent.ok && sent.kind == KIND_GGA) begin
            if (sent.fix == CH_ZERO) pv_next = 1'b0;
            else begin
                hh_next = two_digits(sent.tdig[7:0]);
                mi_next = two_digits(sent.tdig[15:8]);
                ss_next = two_digits(sent.tdig[23:16]);
                lat_next = sent.hemi[0] ? 27'(-mla) : 27'(mla);
                lon_next = sent.hemi[1] ? 28'(-mlo) : 28'(mlo);
                pv_next = 1'b1;
            end
        end
        if (sent.ok && sent.kind == KIND_RMC) begin
            if (sent.status == CH_A) begin
                dd_next = two_digits(sent.ddig[7:0]);
                mo_next = two_digits(sent.ddig[15:8]);
                yy_next = two_digits(sent.ddig[23:16]);
                dv_next = 1'b1;
            end else dv_next = 1'b0;
        end
        res = {2'b00, lon_next, lat_next, yy_next, mo_next, dd_next, ss_next,
               mi_next, hh_next, dv_next, pv_next, sent.ok, sent.kind};
    end

    assign can_take      = !sv_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0; dv_reg <= 1'b0;
            hh_reg <= '0; mi_reg <= '0; ss_reg <= '0;
            dd_reg <= '0; mo_reg <= '0; yy_reg <= '0;
            lat_reg <= '0; lon_reg <= '0;
            ov_reg <= 1'b0; sv_reg <= 1'b0;
        end
        else
        begin
            if (done)
            begin
                pv_reg <= pv_next; dv_reg <= dv_next;
                hh_reg <= hh_next; mi_reg <= mi_next; ss_reg <= ss_next;
                dd_reg <= dd_next; mo_reg <= mo_next; yy_reg <= yy_next;
                lat_reg <= lat_next; lon_reg <= lon_next;
            end
            if (!ov_reg || m_axis_tready)
            begin
                // advance skid into output, else take new request directly
                if (sv_reg)
                begin
                    out_reg <= skid_reg; ov_reg <= 1'b1; sv_reg <= done;
                    if (done) skid_reg <= res;
                end
                else
                begin
                    ov_reg <= done;
                    if (done) out_reg <= res;
                end
            end
            else if (done)
            begin
                skid_reg <= res; sv_reg <= 1'b1;
            end
        end
    end
endmodule

[hdl/nmea_sentence_parser.sv]
// ----------------------------------------------------------------------------
// nmea_sentence_parser
// NMEA 0183 GGA/RMC parser, one received byte per request.
// Output: a CR/LF byte's result is registered, via the skid stage if the output is held.
// Throughput: one byte per cycle; input stalls only when both output
// register and skid stage are full.
// Reset: clears sentence state, held fields and output valid.
// ----------------------------------------------------------------------------
module nmea_sentence_parser
    import nsp_pkg::*;
#(
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF,
    parameter int MAX_FIELDS      = MAX_FIELDS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // rx_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // sentence_kind, checksum_ok, position_valid, date_valid, utc_hour,
    // utc_minute, utc_second, utc_day, utc_month, utc_year,
    // latitude_e4min, longitude_e4min, zero pad
    output logic [103:0] m_axis_tdata
);
    logic  done, can_take;
    sent_t sent;

    assign s_axis_tready = can_take;

    nsp_scan #(.FRACTION_DIGITS(FRACTION_DIGITS), .MAX_FIELDS(MAX_FIELDS)) u_scan (
        .clk(clk), .rst_n(rst_n), .valid(s_axis_tvalid && can_take),
        .c(s_axis_tdata), .done(done), .sent(sent)
    );

    nsp_result #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_res (
        .clk(clk), .rst_n(rst_n), .done(done), .sent(sent), .can_take(can_take),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );
endmodule
